>>> hdl/esrp_pkg.sv
package esrp_pkg;

  // Parse phases
  localparam logic [2:0] PH_HEAD  = 3'd0;
  localparam logic [2:0] PH_PAGE  = 3'd1;
  localparam logic [2:0] PH_DESC  = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  // Result kinds
  localparam logic [2:0] KIND_SLOT   = 3'd0;
  localparam logic [2:0] KIND_PORTAL = 3'd1;
  localparam logic [2:0] KIND_DRIVE  = 3'd2;
  localparam logic [2:0] KIND_OK     = 3'd3;
  localparam logic [2:0] KIND_SHORT  = 3'd4;
  localparam logic [2:0] KIND_TRUNC  = 3'd5;

  // Element type codes in the page header
  localparam logic [7:0] ELEM_STORAGE = 8'd2;
  localparam logic [7:0] ELEM_PORTAL  = 8'd3;
  localparam logic [7:0] ELEM_DRIVE   = 8'd4;

  localparam int TAG_MAX       = 32;
  localparam int TAG_FIRST     = 12;
  localparam int TAG_LAST_EXCL = 44;
  localparam int TAG_MIN_DLEN  = 48;
  localparam int HDR_BYTES     = 8;

  typedef struct packed {
    logic [2:0]           kind;
    logic [15:0]          element_address;
    logic [15:0]          logical_number;
    logic                 full_res;
    logic [15:0]          source_address;
    logic [15:0]          source_slot;
    logic [5:0]           tag_length;
    logic [TAG_MAX*8-1:0] tag_bits;   // byte 0 in the top bits
    logic                 end_of_run;
  } result_t;

endpackage

>>> hdl/esrp_if.sv
interface esrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface esrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] element_address;
  logic [15:0] logical_number;
  logic        full_res;
  logic [15:0] source_address;
  logic [15:0] source_slot;
  logic [5:0]  tag_length;
  logic [63:0] tag_word_0;
  logic [63:0] tag_word_1;
  logic [63:0] tag_word_2;
  logic [63:0] tag_word_3;
  logic        end_of_run;
  modport source (output valid, output kind, output element_address, output logical_number,
                  output full_res, output source_address, output source_slot,
                  output tag_length, output tag_word_0, output tag_word_1,
                  output tag_word_2, output tag_word_3, output end_of_run, input ready);
  modport sink (input valid, input kind, input element_address, input logical_number,
                input full_res, input source_address, input source_slot,
                input tag_length, input tag_word_0, input tag_word_1,
                input tag_word_2, input tag_word_3, input end_of_run, output ready);
endinterface

>>> hdl/element_status_response_parser.sv
// Element-status response parser: takes one response byte per cycle on in_ch and
// emits one record per storage, import/export or drive descriptor, then a final
// status (ok, too short, truncated) on the byte marked last_byte. Each byte is
// parsed in the cycle it is transferred; its results sit in a three-entry output
// queue, so the block sustains one byte per cycle while out_ch keeps up. in_ch
// ready drops while two or more results wait, as happens after the last byte of a
// response when that byte yields both a record and its status.
module element_status_response_parser #(
  parameter int TAG_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  esrp_in_if.sink     in_ch,
  esrp_out_if.source  out_ch
);

  logic              in_accept;
  logic [1:0]        push_n;
  logic [1:0]        q_count;
  esrp_pkg::result_t res0, res1, head;

  assign in_ch.ready = (q_count <= 2'd1);
  assign in_accept   = in_ch.valid && in_ch.ready;

  esrp_parser #(.TAG_BYTES(TAG_BYTES)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .push_n    (push_n),
    .res0      (res0),
    .res1      (res1)
  );

  esrp_out_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .res0   (res0),
    .res1   (res1),
    .pop    (out_ch.valid && out_ch.ready),
    .head   (head),
    .count  (q_count)
  );

  // result channel
  assign out_ch.valid           = (q_count != 2'd0);
  assign out_ch.kind            = head.kind;
  assign out_ch.element_address = head.element_address;
  assign out_ch.logical_number  = head.logical_number;
  assign out_ch.full_res        = head.full_res;
  assign out_ch.source_address  = head.source_address;
  assign out_ch.source_slot     = head.source_slot;
  assign out_ch.tag_length      = head.tag_length;
  assign out_ch.tag_word_0      = head.tag_bits[255:192];
  assign out_ch.tag_word_1      = head.tag_bits[191:128];
  assign out_ch.tag_word_2      = head.tag_bits[127:64];
  assign out_ch.tag_word_3      = head.tag_bits[63:0];
  assign out_ch.end_of_run      = head.end_of_run;

  // a last byte always leaves a status waiting
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_ch.last_byte |=> out_ch.valid)
    else $error("no result after last byte");

  // queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (q_count <= 2'd1) && (push_n != 2'd3))
    else $error("result queue overflow");

  // status results carry end_of_run
  a_status_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == esrp_pkg::KIND_OK || out_ch.kind == esrp_pkg::KIND_SHORT
    || out_ch.kind == esrp_pkg::KIND_TRUNC) |-> out_ch.end_of_run)
    else $error("status without end_of_run");

endmodule

>>> hdl/esrp_parser.sv
module esrp_parser #(
  parameter int TAG_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic [1:0]          push_n,
  output esrp_pkg::result_t   res0,
  output esrp_pkg::result_t   res1
);

  localparam int TAG_MAX_BITS = esrp_pkg::TAG_MAX * 8;

  logic [2:0]  phase_r, phase_nxt;
  logic [24:0] cnt_r, cnt_nxt;
  logic [23:0] body_r, body_nxt;
  logic [23:0] pr_r, pr_nxt;
  logic [7:0]  pkind_r, pkind_nxt;
  logic        tags_r, tags_nxt;
  logic [15:0] dl_r, dl_nxt;
  logic [15:0] dc_r, dc_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic        full_r, full_nxt;
  logic        sv_r, sv_nxt;
  logic [15:0] src_r, src_nxt;
  logic [TAG_BYTES*8-1:0] tag_r, tag_nxt;
  logic [5:0]  tend_r, tend_nxt;
  logic [15:0] fslot_r, fslot_nxt;
  logic [15:0] fport_r, fport_nxt;
  logic [15:0] fdrive_r, fdrive_nxt;
  logic [2:0]  seen_r, seen_nxt;

  esrp_pkg::result_t rec, st;
  logic        rec_valid;
  logic [24:0] cnt_inc, body_end, left, end_chk;
  logic [16:0] dc_inc;
  logic [23:0] pr_dec;
  logic [15:0] tidx, srcv, logical, slot;
  logic [TAG_MAX_BITS-1:0] tag_full;

  // Phase after a header or descriptor: next descriptor, skip, or next page
  function automatic logic [2:0] next_in_page(input logic [23:0] pr, input logic [15:0] dl);
    logic [2:0] ph;
    if (pr == '0) ph = esrp_pkg::PH_PAGE;
    else if (pr >= {8'h00, dl}) ph = esrp_pkg::PH_DESC;
    else ph = esrp_pkg::PH_SKIP;
    return ph;
  endfunction

  // Per-byte parse
  always_comb begin
    phase_nxt = phase_r; cnt_nxt = cnt_r; body_nxt = body_r; pr_nxt = pr_r;
    pkind_nxt = pkind_r; tags_nxt = tags_r; dl_nxt = dl_r; dc_nxt = dc_r;
    addr_nxt = addr_r; full_nxt = full_r; sv_nxt = sv_r; src_nxt = src_r;
    tag_nxt = tag_r; tend_nxt = tend_r; fslot_nxt = fslot_r; fport_nxt = fport_r;
    fdrive_nxt = fdrive_r; seen_nxt = seen_r;
    rec = '0; st = '0; rec_valid = 1'b0;
    cnt_inc  = cnt_r + 25'd1;
    body_end = 25'(esrp_pkg::HDR_BYTES) + {1'b0, body_r};
    left     = body_end - cnt_inc;
    dc_inc   = {1'b0, dc_r} + 17'd1;
    pr_dec   = pr_r - 24'd1;
    tidx     = dc_r - 16'(esrp_pkg::TAG_FIRST);
    srcv = '0; logical = '0; slot = '0; tag_full = '0; end_chk = '0;

    if (accept) begin
      if (phase_r == esrp_pkg::PH_HEAD) begin
        if (cnt_r >= 25'd5) body_nxt = {body_r[15:0], data_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 25'(esrp_pkg::HDR_BYTES)) begin
          dc_nxt = '0;
          phase_nxt = (body_nxt == '0) ? esrp_pkg::PH_DRAIN : esrp_pkg::PH_PAGE;
        end
      end else if (phase_r != esrp_pkg::PH_DRAIN) begin
        cnt_nxt = cnt_inc;
        case (phase_r)
          esrp_pkg::PH_PAGE: begin
            case (dc_r)
              16'd0: pkind_nxt = data_byte;
              16'd1: tags_nxt = data_byte[7];
              16'd2: dl_nxt = {data_byte, 8'h00};
              16'd3: dl_nxt = {dl_r[15:8], data_byte};
              16'd4: ;
              16'd5: pr_nxt = {16'h0000, data_byte};
              default: pr_nxt = {pr_r[15:0], data_byte};
            endcase
            dc_nxt = dc_inc[15:0];
            if (dc_r == 16'd7) begin
              dc_nxt = '0;
              if (dl_nxt != '0 && pr_nxt != '0) begin
                if ({1'b0, pr_nxt} > left) pr_nxt = left[23:0];
                phase_nxt = next_in_page(pr_nxt, dl_nxt);
              end
            end
          end
          esrp_pkg::PH_DESC: begin
            // field capture
            if (dc_r == '0) begin
              full_nxt = 1'b0; sv_nxt = 1'b0; src_nxt = '0; tend_nxt = '0;
            end
            case (dc_r)
              16'd0:  addr_nxt = {data_byte, 8'h00};
              16'd1:  addr_nxt = {addr_r[15:8], data_byte};
              16'd2:  full_nxt = data_byte[0];
              16'd9:  sv_nxt = data_byte[7];
              16'd10: src_nxt = {data_byte, 8'h00};
              16'd11: src_nxt = {src_r[15:8], data_byte};
              default: begin
                if (dc_r >= 16'(esrp_pkg::TAG_FIRST) && dc_r < 16'(esrp_pkg::TAG_LAST_EXCL)
                    && tags_r && dl_r >= 16'(esrp_pkg::TAG_MIN_DLEN)
                    && tidx < 16'(TAG_BYTES)) begin
                  for (int i = 0; i < TAG_BYTES; i++) begin
                    if (tidx == 16'(i)) tag_nxt[(TAG_BYTES-i)*8-1 -: 8] = data_byte;
                  end
                  if (data_byte != 8'h20 && data_byte != 8'h00) tend_nxt = 6'(tidx + 16'd1);
                end
              end
            endcase
            dc_nxt = dc_inc[15:0];
            pr_nxt = pr_dec;
            if (dc_inc >= {1'b0, dl_r}) begin
              dc_nxt = '0;
              phase_nxt = next_in_page(pr_dec, dl_r);
              // record build
              srcv = sv_nxt ? src_nxt : 16'h0000;
              case (pkind_r)
                esrp_pkg::ELEM_STORAGE: begin
                  if (!seen_r[0]) begin fslot_nxt = addr_nxt; seen_nxt[0] = 1'b1; end
                  rec_valid = 1'b1; rec.kind = esrp_pkg::KIND_SLOT;
                  logical = addr_nxt - fslot_nxt + 16'd1;
                end
                esrp_pkg::ELEM_PORTAL: begin
                  if (!seen_r[1]) begin fport_nxt = addr_nxt; seen_nxt[1] = 1'b1; end
                  rec_valid = 1'b1; rec.kind = esrp_pkg::KIND_PORTAL;
                  logical = addr_nxt - fport_nxt + 16'd1;
                end
                esrp_pkg::ELEM_DRIVE: begin
                  if (!seen_r[2]) begin fdrive_nxt = addr_nxt; seen_nxt[2] = 1'b1; end
                  rec_valid = 1'b1; rec.kind = esrp_pkg::KIND_DRIVE;
                  logical = addr_nxt - fdrive_nxt;
                  if (full_nxt && sv_nxt && seen_r[0] && srcv >= fslot_r)
                    slot = srcv - fslot_r + 16'd1;
                end
                default: ;
              endcase
              tag_full[TAG_MAX_BITS-1 -: TAG_BYTES*8] = tag_nxt;
              for (int j = 0; j < esrp_pkg::TAG_MAX; j++) begin
                if (6'(j) >= tend_nxt) tag_full[(esrp_pkg::TAG_MAX-j)*8-1 -: 8] = 8'h00;
              end
              rec.element_address = addr_nxt;
              rec.logical_number  = logical;
              rec.full_res        = full_nxt;
              rec.source_address  = srcv;
              rec.source_slot     = slot;
              rec.tag_length      = tend_nxt;
              rec.tag_bits        = tag_full;
              rec.end_of_run      = !last_byte;
            end
          end
          default: begin
            if (pr_r != '0) pr_nxt = pr_dec;
            if (pr_nxt == '0) begin dc_nxt = '0; phase_nxt = esrp_pkg::PH_PAGE; end
          end
        endcase
        if (cnt_inc >= body_end) phase_nxt = esrp_pkg::PH_DRAIN;
      end

      // final status, then back to reset state
      if (last_byte) begin
        end_chk = 25'(esrp_pkg::HDR_BYTES) + {1'b0, body_nxt};
        if (phase_nxt == esrp_pkg::PH_HEAD) st.kind = esrp_pkg::KIND_SHORT;
        else if (cnt_nxt < end_chk) st.kind = esrp_pkg::KIND_TRUNC;
        else st.kind = esrp_pkg::KIND_OK;
        st.end_of_run = 1'b1;
        phase_nxt = esrp_pkg::PH_HEAD; cnt_nxt = '0; body_nxt = '0; pr_nxt = '0;
        pkind_nxt = '0; tags_nxt = 1'b0; dl_nxt = '0; dc_nxt = '0; addr_nxt = '0;
        full_nxt = 1'b0; sv_nxt = 1'b0; src_nxt = '0; tend_nxt = '0;
        fslot_nxt = '0; fport_nxt = '0; fdrive_nxt = '0; seen_nxt = '0;
      end
    end
  end

  // results handed to the queue
  always_comb begin
    push_n = 2'({1'b0, rec_valid} + {1'b0, accept & last_byte});
    res0 = rec_valid ? rec : st;
    res1 = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= esrp_pkg::PH_HEAD; cnt_r <= '0; body_r <= '0; pr_r <= '0;
      pkind_r <= '0; tags_r <= 1'b0; dl_r <= '0; dc_r <= '0; addr_r <= '0;
      full_r <= 1'b0; sv_r <= 1'b0; src_r <= '0; tend_r <= '0;
      fslot_r <= '0; fport_r <= '0; fdrive_r <= '0; seen_r <= '0;
    end else begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; body_r <= body_nxt; pr_r <= pr_nxt;
      pkind_r <= pkind_nxt; tags_r <= tags_nxt; dl_r <= dl_nxt; dc_r <= dc_nxt;
      addr_r <= addr_nxt; full_r <= full_nxt; sv_r <= sv_nxt; src_r <= src_nxt;
      tend_r <= tend_nxt; fslot_r <= fslot_nxt; fport_r <= fport_nxt;
      fdrive_r <= fdrive_nxt; seen_r <= seen_nxt;
    end
  end

  // tag bytes: masked by tag length on output, no reset needed
  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule

>>> hdl/esrp_out_queue.sv
module esrp_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  esrp_pkg::result_t res0,
  input  esrp_pkg::result_t res1,
  input  logic              pop,
  output esrp_pkg::result_t head,
  output logic [1:0]        count
);

  esrp_pkg::result_t q_r [3];
  esrp_pkg::result_t q_nxt [3];
  logic [1:0] cnt_r, cnt_nxt, base;

  // shift out the head on a transfer, append new results behind
  always_comb begin
    base = cnt_r - {1'b0, pop};
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    for (int i = 0; i < 3; i++) begin
      if (push_n != 2'd0 && base == 2'(i)) q_nxt[i] = res0;
      if (push_n == 2'd2 && base + 2'd1 == 2'(i)) q_nxt[i] = res1;
    end
    cnt_nxt = base + push_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) q_r[i] <= q_nxt[i];
  end

  assign head  = q_r[0];
  assign count = cnt_r;

endmodule

>>> verif/tb_element_status_response_parser.sv
module tb_element_status_response_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int ITEM_TARGET = 1700;

  logic clk = 1'b0;
  logic rst_n;

  esrp_in_if  in_ch();
  esrp_out_if out_ch();

  element_status_response_parser dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       last_byte;
    bit         has_status;
    logic [2:0] status;
  } directed_row_t;

  esrp_pkg::result_t record_q[$];
  byte_item_t        resp_q[$];
  int                err_count = 0;
  bit                idle_on = 1'b1;
  logic [2:0]        newest_status;

  // Parser mirror state
  logic [2:0]   ph;
  int unsigned  rcnt;
  logic [23:0]  blen;
  logic [23:0]  prem;
  logic [7:0]   pkind;
  logic         tagp;
  logic [15:0]  dlen;
  logic [15:0]  dcnt;
  logic [15:0]  caddr;
  logic         cfull;
  logic         sval;
  logic [15:0]  csrc;
  logic [255:0] tagst;
  logic [5:0]   tend;
  logic [15:0]  fslot, fport, fdrv;
  logic [2:0]   seen;

  function automatic void parser_clear();
    ph = esrp_pkg::PH_HEAD; rcnt = 0; blen = '0; prem = '0; pkind = '0; tagp = 1'b0;
    dlen = '0; dcnt = '0; caddr = '0; cfull = 1'b0; sval = 1'b0; csrc = '0;
    tagst = '0; tend = '0; fslot = '0; fport = '0; fdrv = '0; seen = '0;
  endfunction

  function automatic void advance_in_page();
    dcnt = '0;
    if (prem == 0) ph = esrp_pkg::PH_PAGE;
    else if (prem >= dlen) ph = esrp_pkg::PH_DESC;
    else ph = esrp_pkg::PH_SKIP;
  endfunction

  function automatic void capture_desc_byte(int k, logic [7:0] b);
    int i;
    if (k == 0) begin
      cfull = 1'b0; sval = 1'b0; csrc = '0; tagst = '0; tend = '0;
      caddr = {b, 8'h00};
    end else if (k == 1) caddr[7:0] = b;
    else if (k == 2) cfull = b[0];
    else if (k == 9) sval = b[7];
    else if (k == 10) csrc = {b, 8'h00};
    else if (k == 11) csrc[7:0] = b;
    else if (k >= esrp_pkg::TAG_FIRST && k < esrp_pkg::TAG_LAST_EXCL && tagp
             && dlen >= esrp_pkg::TAG_MIN_DLEN) begin
      i = k - esrp_pkg::TAG_FIRST;
      tagst[255-8*i -: 8] = b;
      if (b != 8'h20 && b != 8'h00) tend = 6'(i + 1);
    end
  endfunction

  // Build the element record for the finished descriptor
  function automatic bit element_record(output esrp_pkg::result_t r);
    logic [15:0] src;
    src = sval ? csrc : 16'h0;
    r = '0;
    r.element_address = caddr;
    r.full_res = cfull;
    r.source_address = src;
    if (pkind == esrp_pkg::ELEM_STORAGE) begin
      if (!seen[0]) begin fslot = caddr; seen[0] = 1'b1; end
      r.kind = esrp_pkg::KIND_SLOT;
      r.logical_number = caddr - fslot + 16'd1;
    end else if (pkind == esrp_pkg::ELEM_PORTAL) begin
      if (!seen[1]) begin fport = caddr; seen[1] = 1'b1; end
      r.kind = esrp_pkg::KIND_PORTAL;
      r.logical_number = caddr - fport + 16'd1;
    end else if (pkind == esrp_pkg::ELEM_DRIVE) begin
      if (!seen[2]) begin fdrv = caddr; seen[2] = 1'b1; end
      r.kind = esrp_pkg::KIND_DRIVE;
      r.logical_number = caddr - fdrv;
      if (cfull && sval && seen[0] && src >= fslot) r.source_slot = src - fslot + 16'd1;
    end else begin
      return 1'b0;
    end
    r.tag_length = tend;
    for (int i = 0; i < esrp_pkg::TAG_MAX; i++)
      if (i < tend) r.tag_bits[255-8*i -: 8] = tagst[255-8*i -: 8];
    return 1'b1;
  endfunction

  // Advance the mirror by one transferred byte and queue its results
  function automatic void parse_byte(logic [7:0] b, logic last);
    esrp_pkg::result_t rec;
    esrp_pkg::result_t st;
    bit                got;
    int unsigned       bend;
    int unsigned       left;
    got = 1'b0;
    if (ph == esrp_pkg::PH_HEAD) begin
      if (rcnt >= 5) blen = {blen[15:0], b};
      rcnt++;
      if (rcnt >= esrp_pkg::HDR_BYTES) begin
        dcnt = '0;
        ph = (blen == 0) ? esrp_pkg::PH_DRAIN : esrp_pkg::PH_PAGE;
      end
    end else if (ph != esrp_pkg::PH_DRAIN) begin
      bend = esrp_pkg::HDR_BYTES + blen;
      rcnt++;
      if (ph == esrp_pkg::PH_PAGE) begin
        case (dcnt)
          0: pkind = b;
          1: tagp = b[7];
          2: dlen = {b, 8'h00};
          3: dlen[7:0] = b;
          4: ;
          5: prem = {16'h0, b};
          default: prem = {prem[15:0], b};
        endcase
        dcnt++;
        if (dcnt >= 8) begin
          dcnt = '0;
          if (dlen != 0 && prem != 0) begin
            left = bend - rcnt;
            if (prem > left) prem = 24'(left);
            advance_in_page();
          end
        end
      end else if (ph == esrp_pkg::PH_DESC) begin
        capture_desc_byte(dcnt, b);
        dcnt++;
        prem--;
        if (dcnt >= dlen) begin
          got = element_record(rec);
          advance_in_page();
        end
      end else begin
        if (prem > 0) prem--;
        if (prem == 0) begin dcnt = '0; ph = esrp_pkg::PH_PAGE; end
      end
      if (rcnt >= bend) ph = esrp_pkg::PH_DRAIN;
    end
    if (got) begin
      rec.end_of_run = !last;
      record_q.insert(record_q.size(), rec);
    end
    if (last) begin
      st = '0;
      if (ph == esrp_pkg::PH_HEAD) st.kind = esrp_pkg::KIND_SHORT;
      else if (rcnt < esrp_pkg::HDR_BYTES + blen) st.kind = esrp_pkg::KIND_TRUNC;
      else st.kind = esrp_pkg::KIND_OK;
      st.end_of_run = 1'b1;
      newest_status = st.kind;
      record_q.insert(record_q.size(), st);
      parser_clear();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Source side: one transfer per call, optional gap before it
  task automatic send_byte(logic [7:0] b, logic last);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    parse_byte(b, last);
  endtask

  // Append one byte to the response being built
  function automatic void queue_byte(logic [7:0] d, logic l);
    byte_item_t it;
    it.data_byte = d;
    it.last_byte = l;
    resp_q.insert(resp_q.size(), it);
  endfunction

  // Random response: mostly well-formed pages, some noise and damaged framing
  task automatic build_response();
    logic [7:0]  body[$];
    int          npages, ndesc, pbytes, taglen, total, cut, sel;
    logic [15:0] dl, addr, src;
    logic [7:0]  pk, ch;
    bit          tg;
    body.delete();
    resp_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      total = $urandom_range(1, 40);
      for (int i = 0; i < total; i++) queue_byte(8'($urandom), (i == total - 1));
      return;
    end
    npages = $urandom_range(1, 3);
    for (int p = 0; p < npages; p++) begin
      sel = $urandom_range(0, 9);
      pk = (sel < 3) ? esrp_pkg::ELEM_STORAGE : (sel < 5) ? esrp_pkg::ELEM_PORTAL :
           (sel < 8) ? esrp_pkg::ELEM_DRIVE : (sel == 8) ? 8'd1 : 8'($urandom);
      tg = $urandom_range(0, 1);
      sel = $urandom_range(0, 19);
      dl = (sel < 6) ? 16'd12 : (sel < 10) ? 16'd16 : (sel < 14) ? 16'd48 :
           (sel < 16) ? 16'd52 : (sel < 19) ? 16'($urandom_range(1, 64)) : 16'd0;
      ndesc = $urandom_range(1, 3);
      pbytes = ndesc * dl;
      if ($urandom_range(0, 7) == 0 && dl > 1) pbytes += $urandom_range(1, dl - 1);
      if ($urandom_range(0, 15) == 0) pbytes = 0;
      body.insert(body.size(), pk);
      body.insert(body.size(), {tg, 7'($urandom)});
      body.insert(body.size(), dl[15:8]);
      body.insert(body.size(), dl[7:0]);
      body.insert(body.size(), 8'($urandom));
      body.insert(body.size(), 8'(pbytes >> 16));
      body.insert(body.size(), 8'(pbytes >> 8));
      body.insert(body.size(), 8'(pbytes));
      if (pbytes == 0) continue;
      addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      for (int d = 0; d < pbytes / (dl == 0 ? 1 : dl); d++) begin
        taglen = $urandom_range(0, 32);
        src = ($urandom_range(0, 1)) ? addr - 16'($urandom_range(0, 20)) : 16'($urandom);
        for (int k = 0; k < dl; k++) begin
          case (k)
            0: ch = addr[15:8];
            1: ch = addr[7:0];
            10: ch = src[15:8];
            11: ch = src[7:0];
            default:
              if (k >= 12 && k < 44)
                ch = (k - 12 < taglen) ? 8'($urandom_range(33, 126)) :
                     ($urandom_range(0, 1) ? 8'h20 : 8'h00);
              else ch = 8'($urandom);
          endcase
          body.insert(body.size(), ch);
        end
        addr = addr + 16'($urandom_range(1, 2));
      end
      for (int k = 0; k < pbytes % (dl == 0 ? 1 : dl); k++)
        body.insert(body.size(), 8'($urandom));
    end
    total = body.size();
    sel = $urandom_range(0, 99);
    if (sel >= 93) total = total + $urandom_range(0, 40) - 20;
    if (total < 0) total = 0;
    for (int i = 0; i < 5; i++) queue_byte(8'($urandom), 1'b0);
    queue_byte(8'(total >> 16), 1'b0);
    queue_byte(8'(total >> 8), 1'b0);
    queue_byte(8'(total), 1'b0);
    foreach (body[i]) queue_byte(body[i], 1'b0);
    if (sel >= 86 && sel < 93)
      for (int i = 0; i < $urandom_range(1, 10); i++) queue_byte(8'($urandom), 1'b0);
    if (sel >= 79 && sel < 86 && resp_q.size() > 2) begin
      cut = $urandom_range(1, resp_q.size() - 1);
      while (resp_q.size() > cut) void'(resp_q.pop_back());
    end
    resp_q[$].last_byte = 1'b1;
  endtask

  // Short response, empty body, truncated body
  directed_row_t dir_rows[] = '{
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b1, 1'b1, esrp_pkg::KIND_SHORT},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b1, 1'b1, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'hFF, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h00, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h10, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h02, 1'b0, 1'b0, esrp_pkg::KIND_OK},
    '{8'h80, 1'b1, 1'b1, esrp_pkg::KIND_TRUNC}
  };

  // Stimulus
  initial begin
    int sent;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    parser_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte);
      if (dir_rows[i].has_status && newest_status !== dir_rows[i].status) begin
        $error("directed status: expected %0d, got %0d", dir_rows[i].status, newest_status);
        err_count++;
      end
    end
    sent = 0;
    while (sent < ITEM_TARGET) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_response();
      foreach (resp_q[i]) send_byte(resp_q[i].data_byte, resp_q[i].last_byte);
      sent += resp_q.size();
    end
    in_ch.valid <= 1'b0;
    while (record_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      err_count++;
    end
  endtask

  // Sink side: random stalls and result checking
  int stall_left = 0;
  always @(posedge clk) begin
    esrp_pkg::result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (record_q.size() == 0) begin
          $error("result transfer with nothing expected, kind %0d", out_ch.kind);
          err_count++;
        end else begin
          e = record_q.pop_front();
          check_field("kind", e.kind, out_ch.kind);
          check_field("element_address", e.element_address, out_ch.element_address);
          check_field("logical_number", e.logical_number, out_ch.logical_number);
          check_field("full_res", e.full_res, out_ch.full_res);
          check_field("source_address", e.source_address, out_ch.source_address);
          check_field("source_slot", e.source_slot, out_ch.source_slot);
          check_field("tag_length", e.tag_length, out_ch.tag_length);
          check_field("tag_word_0", e.tag_bits[255:192], out_ch.tag_word_0);
          check_field("tag_word_1", e.tag_bits[191:128], out_ch.tag_word_1);
          check_field("tag_word_2", e.tag_bits[127:64], out_ch.tag_word_2);
          check_field("tag_word_3", e.tag_bits[63:0], out_ch.tag_word_3);
          check_field("end_of_run", e.end_of_run, out_ch.end_of_run);
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog on cycles without any transfer
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
